/* hdl/mxs_pkg.sv */
// ----------------------------------------------------------------------------
// mxs_pkg - shared types and helpers for the max stack
// Data word type, opcodes, cell commands and the running-maximum compare.
// ----------------------------------------------------------------------------
package mxs_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;
    localparam int OP_W   = 2;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_POPMAX = 2'd2,
        OP_PEEK   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_PUSH = 3'd1,
        CELL_POP  = 3'd2,
        CELL_DEL  = 3'd3,
        CELL_FIX  = 3'd4
    } cell_op_t;

    // An entry owns the running maximum when nothing older is valid or it is
    // at least the older maximum; ties go to the newer entry.
    function automatic logic owns_max(word_t v, word_t below_max, logic below_ok);
        return !below_ok || (v >= below_max);
    endfunction

endpackage

/* hdl/max_stack.sv */
// ----------------------------------------------------------------------------
// max_stack - bounded signed stack with pop-maximum
// A row of DEPTH cells with the top of the stack in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start high and
//   busy low; opcode selects push, pop, pop-max or peek, push_value is used
//   by push only.
//   Result channel: done is high for exactly one cycle per command and the
//   result ports hold the beat during that cycle; the receiver cannot stall.
//   Sequence: after acceptance, push, pop, peek and any rejected command
//   pass through EXEC, which acts on the cell row, then RESP, which reports.
//   Pop-max, when entries newer than the removed one exist, runs a repair
//   wave between EXEC and RESP that walks the running maximum up the cell
//   row one cell per cycle.
//   Overlap: busy drops during the result cycle, so a new command can be
//   taken then.
//   Reset: the stack is empty; cell contents are not cleared and are never
//   seen, since only occupied cells reach the outputs.
// ----------------------------------------------------------------------------
module max_stack #(
    parameter int DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mxs_pkg::OP_W-1:0]       opcode,
    input  mxs_pkg::word_t                 push_value,
    output logic                           busy,
    output logic                           done,
    output mxs_pkg::word_t                 removed_value,
    output mxs_pkg::word_t                 top_value,
    output mxs_pkg::word_t                 max_value,
    output logic [mxs_pkg::OCC_W-1:0]      occupancy,
    output logic                           is_empty,
    output logic                           op_error
);
    import mxs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    cell_op_t      cell_op;
    logic [IW-1:0] sel_idx;
    logic [CW-1:0] count;
    word_t         new_val;
    word_t         new_smax;
    logic [IW-1:0] new_dist;

    word_t         cell_val  [DEPTH];
    word_t         cell_smax [DEPTH];
    logic [IW-1:0] cell_dist [DEPTH];

    mxs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .push_value    (push_value),
        .busy          (busy),
        .done          (done),
        .removed_value (removed_value),
        .top_value     (top_value),
        .max_value     (max_value),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .op_error      (op_error),
        .cell_op       (cell_op),
        .sel_idx       (sel_idx),
        .count         (count),
        .new_val       (new_val),
        .new_smax      (new_smax),
        .new_dist      (new_dist),
        .head_val      (cell_val[0]),
        .head_smax     (cell_smax[0]),
        .head_dist     (cell_dist[0])
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t         up_val;
        word_t         up_smax;
        logic [IW-1:0] up_dist;
        word_t         dn_val;
        word_t         dn_smax;
        logic [IW-1:0] dn_dist;

        if (i == 0)
        begin : g_head
            assign up_val  = new_val;
            assign up_smax = new_smax;
            assign up_dist = new_dist;
        end
        else
        begin : g_inner_up
            assign up_val  = cell_val[i-1];
            assign up_smax = cell_smax[i-1];
            assign up_dist = cell_dist[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign dn_val  = '0;
            assign dn_smax = '0;
            assign dn_dist = '0;
        end
        else
        begin : g_inner_dn
            assign dn_val  = cell_val[i+1];
            assign dn_smax = cell_smax[i+1];
            assign dn_dist = cell_dist[i+1];
        end

        mxs_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .cell_op  (cell_op),
            .sel_idx  (sel_idx),
            .count    (count),
            .up_val   (up_val),
            .up_smax  (up_smax),
            .up_dist  (up_dist),
            .dn_val   (dn_val),
            .dn_smax  (dn_smax),
            .dn_dist  (dn_dist),
            .val      (cell_val[i]),
            .smax     (cell_smax[i]),
            .own_dist (cell_dist[i])
        );
    end

endmodule

/* hdl/mxs_cell.sv */
// ----------------------------------------------------------------------------
// mxs_cell - one stack slot
// Holds a value, the maximum of itself and all older slots, and the distance
// down to the slot that owns that maximum. Shifts to either neighbor.
// ----------------------------------------------------------------------------
module mxs_cell #(
    parameter int DEPTH = 64,
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  mxs_pkg::cell_op_t            cell_op,
    input  logic [$clog2(DEPTH)-1:0]     sel_idx,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  mxs_pkg::word_t               up_val,
    input  mxs_pkg::word_t               up_smax,
    input  logic [$clog2(DEPTH)-1:0]     up_dist,
    input  mxs_pkg::word_t               dn_val,
    input  mxs_pkg::word_t               dn_smax,
    input  logic [$clog2(DEPTH)-1:0]     dn_dist,
    output mxs_pkg::word_t               val,
    output mxs_pkg::word_t               smax,
    output logic [$clog2(DEPTH)-1:0]     own_dist
);
    import mxs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    word_t         val_reg;
    word_t         val_next;
    word_t         smax_reg;
    word_t         smax_next;
    logic [IW-1:0] dist_reg;
    logic [IW-1:0] dist_next;
    logic          below_ok;

    assign below_ok = CW'(INDEX + 1) < count;

    always_comb
    begin
        val_next  = val_reg;
        smax_next = smax_reg;
        dist_next = dist_reg;
        case (cell_op)
            CELL_PUSH:
            begin
                val_next  = up_val;
                smax_next = up_smax;
                dist_next = up_dist;
            end
            CELL_POP:
            begin
                val_next  = dn_val;
                smax_next = dn_smax;
                dist_next = dn_dist;
            end
            CELL_DEL:
            begin
                // close the gap: slots at and below the removed one pull up
                if (IW'(INDEX) >= sel_idx)
                begin
                    val_next  = dn_val;
                    smax_next = dn_smax;
                    dist_next = dn_dist;
                end
            end
            CELL_FIX:
            begin
                // rebuild the running maximum from the older neighbor
                if (IW'(INDEX) == sel_idx)
                begin
                    if (owns_max(val_reg, dn_smax, below_ok))
                    begin
                        smax_next = val_reg;
                        dist_next = '0;
                    end
                    else
                    begin
                        smax_next = dn_smax;
                        dist_next = dn_dist + IW'(1);
                    end
                end
            end
            default:
            begin
                val_next  = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        smax_reg <= smax_next;
        dist_reg <= dist_next;
    end

    assign val      = val_reg;
    assign smax     = smax_reg;
    assign own_dist = dist_reg;

endmodule

/* hdl/mxs_ctrl.sv */
// ----------------------------------------------------------------------------
// mxs_ctrl - operation sequencer for the max stack
// Accepts commands, drives the cell row, runs the repair wave after a
// pop-max and presents one result beat per command.
// ----------------------------------------------------------------------------
module mxs_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mxs_pkg::OP_W-1:0]       opcode,
    input  mxs_pkg::word_t                 push_value,
    output logic                           busy,
    output logic                           done,
    output mxs_pkg::word_t                 removed_value,
    output mxs_pkg::word_t                 top_value,
    output mxs_pkg::word_t                 max_value,
    output logic [mxs_pkg::OCC_W-1:0]      occupancy,
    output logic                           is_empty,
    output logic                           op_error,
    output mxs_pkg::cell_op_t              cell_op,
    output logic [$clog2(DEPTH)-1:0]       sel_idx,
    output logic [$clog2(DEPTH+1)-1:0]     count,
    output mxs_pkg::word_t                 new_val,
    output mxs_pkg::word_t                 new_smax,
    output logic [$clog2(DEPTH)-1:0]       new_dist,
    input  mxs_pkg::word_t                 head_val,
    input  mxs_pkg::word_t                 head_smax,
    input  logic [$clog2(DEPTH)-1:0]       head_dist
);
    import mxs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_FIX  = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    opcode_t       op_reg;
    word_t         value_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] sel_reg;
    logic [IW-1:0] sel_next;
    word_t         removed_reg;
    word_t         removed_next;
    logic          err_reg;
    logic          err_next;
    logic          accept;
    logic          stack_empty;
    logic          push_owns;

    assign busy        = !(state_reg == ST_IDLE || state_reg == ST_RESP);
    assign accept      = start && !busy;
    assign stack_empty = (count_reg == '0);

    // entry that lands on top for a push
    assign push_owns = owns_max(value_reg, head_smax, !stack_empty);
    assign new_val   = value_reg;
    assign new_smax  = push_owns ? value_reg : head_smax;
    assign new_dist  = push_owns ? '0 : head_dist + IW'(1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sel_next     = sel_reg;
        removed_next = removed_reg;
        err_next     = err_reg;
        cell_op      = CELL_HOLD;
        sel_idx      = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                removed_next = '0;
                err_next     = 1'b0;
                state_next   = ST_RESP;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cell_op    = CELL_PUSH;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_POP:
                    begin
                        if (stack_empty)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cell_op      = CELL_POP;
                            count_next   = count_reg - CW'(1);
                            removed_next = head_val;
                        end
                    end
                    OP_POPMAX:
                    begin
                        if (stack_empty)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cell_op      = CELL_DEL;
                            sel_idx      = head_dist;
                            count_next   = count_reg - CW'(1);
                            removed_next = head_smax;
                            // newer slots above the gap need their maximum rebuilt
                            if (head_dist != '0)
                            begin
                                sel_next   = head_dist - IW'(1);
                                state_next = ST_FIX;
                            end
                        end
                    end
                    default:
                    begin
                        cell_op = CELL_HOLD;
                    end
                endcase
            end
            ST_FIX:
            begin
                cell_op = CELL_FIX;
                if (sel_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    sel_next = sel_reg - IW'(1);
                end
            end
            ST_RESP:
            begin
                state_next = accept ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            sel_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sel_reg   <= sel_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        if (accept)
        begin
            op_reg    <= opcode_t'(opcode);
            value_reg <= push_value;
        end
    end

    assign count         = count_reg;
    assign done          = (state_reg == ST_RESP);
    assign removed_value = removed_reg;
    assign top_value     = stack_empty ? '0 : head_val;
    assign max_value     = stack_empty ? '0 : head_smax;
    assign occupancy     = OCC_W'(count_reg);
    assign is_empty      = stack_empty;
    assign op_error      = err_reg;

endmodule
